FILE: sv/hkvt_pkg.sv
// ----------------------------------------------------------------------------
// Hashed key/value table package
// Field widths, request and status codes, and the controller state type.
// ----------------------------------------------------------------------------
package hkvt_pkg;

   localparam int KEY_BITS    = 31;
   localparam int VAL_BITS    = 16;
   localparam int REQ_BITS    = 2;
   localparam int STATUS_BITS = 3;

   localparam logic [REQ_BITS-1:0] REQ_INSERT = 2'd0;
   localparam logic [REQ_BITS-1:0] REQ_DELETE = 2'd1;
   localparam logic [REQ_BITS-1:0] REQ_LOOKUP = 2'd2;

   localparam logic [STATUS_BITS-1:0] ST_INSERTED = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_UPDATED  = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_HIT      = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_MISS     = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_FULL     = 3'd4;

   typedef enum logic [4:0] {
      S_CLEAR  = 5'b00001,
      S_IDLE   = 5'b00010,
      S_SCALE  = 5'b00100,
      S_READ   = 5'b01000,
      S_UPDATE = 5'b10000
   } hkvt_state_type;

endpackage

FILE: sv/hashed_key_value_table.sv
// ----------------------------------------------------------------------------
// Hashed key/value table
// Bucketed keyed store with insert-or-update, delete and lookup requests.
// ----------------------------------------------------------------------------
// Usage:
// A request transaction on the req_ channel carries a request code, a key
// and two value words. Each request yields exactly one response transaction
// on the rsp_ channel with a status and, on a lookup hit, the value words.
// The bucket is the key modulo BUCKETS, found with a reciprocal multiply,
// a multiply back and one correcting subtract. Each bucket is one row of
// WAYS slots in a synchronous memory, and the request is served by a
// read-modify-write of that row.
// A request is served in four steps: accept and form the reciprocal
// product, the multiply back, the remainder and the row read, and
// compare, write back and load the response. No new request is taken
// until the last step is done; the response is registered in that step.
// After reset the valid marks are cleared one bucket per cycle, so no request
// is accepted until every bucket has been cleared.
// A new request is accepted while a response waits on a stalled receiver;
// that request then holds in its last step until the response is taken.
// ----------------------------------------------------------------------------
module hashed_key_value_table #(
   parameter int BUCKETS    = 1024,
   parameter int WAYS       = 4,
   parameter int VALUE_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [hkvt_pkg::REQ_BITS-1:0]     req_type,
   input  logic [hkvt_pkg::KEY_BITS-1:0]     req_key,
   input  logic [hkvt_pkg::VAL_BITS-1:0]     req_first_value,
   input  logic [hkvt_pkg::VAL_BITS-1:0]     req_second_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [hkvt_pkg::STATUS_BITS-1:0]  rsp_status,
   output logic [hkvt_pkg::VAL_BITS-1:0]     rsp_out_first,
   output logic [hkvt_pkg::VAL_BITS-1:0]     rsp_out_second
);

   import hkvt_pkg::*;

   localparam int SB        = (VALUE_BITS < VAL_BITS) ? VALUE_BITS : VAL_BITS;
   localparam int SLOT_BITS = KEY_BITS + 2 * SB;
   localparam int IDX_BITS  = $clog2(BUCKETS);
   localparam int BUCKET_W  = $clog2(BUCKETS + 1);
   localparam int REM_BITS  = BUCKET_W + 1;
   localparam int WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int SHIFT     = KEY_BITS + IDX_BITS;
   localparam int PROD_BITS = KEY_BITS + 32;
   localparam int QB_BITS   = KEY_BITS + BUCKET_W;

   localparam logic [63:0] RECIP_WIDE = (64'd1 << SHIFT) / 64'(BUCKETS);
   localparam logic [31:0] RECIP      = RECIP_WIDE[31:0];
   localparam logic [BUCKET_W-1:0] BUCKETS_MUL = BUCKET_W'(BUCKETS);
   localparam logic [REM_BITS-1:0] BUCKETS_REM = REM_BITS'(BUCKETS);
   localparam logic [IDX_BITS-1:0] LAST_IDX    = IDX_BITS'(BUCKETS - 1);

   logic [WAYS-1:0]                 valid_mem [BUCKETS];
   logic [WAYS-1:0][SLOT_BITS-1:0]  data_mem  [BUCKETS];

   hkvt_state_type                  state_ff, state_in;
   logic [IDX_BITS-1:0]             clr_ff, clr_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   logic [REQ_BITS-1:0]             req_type_ff;
   logic [KEY_BITS-1:0]             key_ff;
   logic [SB-1:0]                   first_ff;
   logic [SB-1:0]                   second_ff;
   logic [PROD_BITS-1:0]            prod_ff;
   logic [KEY_BITS-1:0]             qb_ff;
   logic [IDX_BITS-1:0]             idx_ff;
   logic [WAYS-1:0]                 valid_rd_ff;
   logic [WAYS-1:0][SLOT_BITS-1:0]  data_rd_ff;
   logic [STATUS_BITS-1:0]          status_ff;
   logic [VAL_BITS-1:0]             out_first_ff;
   logic [VAL_BITS-1:0]             out_second_ff;

   logic                            accept;
   logic                            update_fire;
   logic [PROD_BITS-1:0]            prod_in;
   logic [PROD_BITS-1:0]            prod_shift;
   logic [QB_BITS-1:0]              qb_full;
   logic [KEY_BITS-1:0]             diff;
   logic [REM_BITS-1:0]             rem_raw;
   logic [REM_BITS-1:0]             rem_fix;
   logic [IDX_BITS-1:0]             idx_in;

   logic [WAYS-1:0]                 match;
   logic                            hit;
   logic [WAY_BITS-1:0]             hit_way;
   logic                            free;
   logic [WAY_BITS-1:0]             free_way;
   logic [SLOT_BITS-1:0]            new_slot;
   logic [WAYS-1:0]                 valid_wr;
   logic [WAYS-1:0][SLOT_BITS-1:0]  data_wr;
   logic [STATUS_BITS-1:0]          status_in;
   logic [VAL_BITS-1:0]             out_first_in;
   logic [VAL_BITS-1:0]             out_second_in;

   logic                            valid_we;
   logic [IDX_BITS-1:0]             valid_waddr;
   logic [WAYS-1:0]                 valid_wdata;

   assign accept      = (state_ff == S_IDLE) && req_valid;
   assign update_fire = (state_ff == S_UPDATE) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = (state_ff != S_IDLE);

   // Bucket index: reciprocal estimate, multiply back, one correction.
   assign prod_in    = PROD_BITS'(req_key) * PROD_BITS'(RECIP);
   assign prod_shift = prod_ff >> SHIFT;
   assign qb_full    = QB_BITS'(prod_shift[KEY_BITS-1:0]) * QB_BITS'(BUCKETS_MUL);
   assign diff       = key_ff - qb_ff;
   assign rem_raw    = diff[REM_BITS-1:0];
   assign rem_fix    = (rem_raw >= BUCKETS_REM) ? (rem_raw - BUCKETS_REM) : rem_raw;
   assign idx_in     = rem_fix[IDX_BITS-1:0];

   assign new_slot = {second_ff, first_ff, key_ff};

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         match[w] = valid_rd_ff[w] && (data_rd_ff[w][KEY_BITS-1:0] == key_ff);
      end
      hit      = 1'b0;
      hit_way  = '0;
      free     = 1'b0;
      free_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (match[w]) begin
            hit     = 1'b1;
            hit_way = WAY_BITS'(w);
         end
         if (!valid_rd_ff[w]) begin
            free     = 1'b1;
            free_way = WAY_BITS'(w);
         end
      end
   end

   always_comb begin
      valid_wr      = valid_rd_ff;
      data_wr       = data_rd_ff;
      status_in     = ST_MISS;
      out_first_in  = '0;
      out_second_in = '0;
      unique case (req_type_ff)
         REQ_INSERT: begin
            if (hit) begin
               data_wr[hit_way] = new_slot;
               status_in        = ST_UPDATED;
            end else if (free) begin
               valid_wr[free_way] = 1'b1;
               data_wr[free_way]  = new_slot;
               status_in          = ST_INSERTED;
            end else begin
               status_in = ST_FULL;
            end
         end
         REQ_DELETE: begin
            if (hit) begin
               valid_wr[hit_way] = 1'b0;
               status_in         = ST_HIT;
            end
         end
         REQ_LOOKUP: begin
            if (hit) begin
               out_first_in  = VAL_BITS'(data_rd_ff[hit_way][KEY_BITS +: SB]);
               out_second_in = VAL_BITS'(data_rd_ff[hit_way][KEY_BITS + SB +: SB]);
               status_in     = ST_HIT;
            end
         end
         default: begin
            status_in = ST_MISS;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            state_in = S_READ;
         end
         S_READ: begin
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            if (update_fire) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_type_ff <= req_type;
         key_ff      <= req_key;
         first_ff    <= req_first_value[SB-1:0];
         second_ff   <= req_second_value[SB-1:0];
         prod_ff     <= prod_in;
      end
      if (state_ff == S_SCALE) begin
         qb_ff <= qb_full[KEY_BITS-1:0];
      end
      if (state_ff == S_READ) begin
         idx_ff <= idx_in;
      end
      if (update_fire) begin
         status_ff     <= status_in;
         out_first_ff  <= out_first_in;
         out_second_ff <= out_second_in;
      end
   end

   assign valid_we    = (state_ff == S_CLEAR) || update_fire;
   assign valid_waddr = (state_ff == S_CLEAR) ? clr_ff : idx_ff;
   assign valid_wdata = (state_ff == S_CLEAR) ? '0 : valid_wr;

   always_ff @(posedge clock) begin
      if (valid_we) begin
         valid_mem[valid_waddr] <= valid_wdata;
      end
      if (state_ff == S_READ) begin
         valid_rd_ff <= valid_mem[idx_in];
      end
   end

   always_ff @(posedge clock) begin
      if (update_fire) begin
         data_mem[idx_ff] <= data_wr;
      end
      if (state_ff == S_READ) begin
         data_rd_ff <= data_mem[idx_in];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_out_first  = out_first_ff;
   assign rsp_out_second = out_second_ff;

endmodule

FILE: verif/tb_hashed_key_value_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hashed key/value table testbench
// Drives insert, delete, lookup and unused requests through the request
// channel and checks each response against a shadow copy of the bucketed
// table. Keys crowd a few hot buckets, so updates, hits, misses and full
// buckets are all common. The request channel idles and the response channel stalls at random.
// ----------------------------------------------------------------------------
module tb_hashed_key_value_table;
   import hkvt_pkg::*;

   localparam int BUCKETS     = 1024;
   localparam int WAYS        = 4;
   localparam int SLOTS       = BUCKETS * WAYS;
   localparam int HOT_COUNT   = 8;
   localparam int MAX_TAG     = 2097151;
   localparam int RANDOM_REQS = 1400;
   localparam int HOLD_AT     = 600;
   localparam int HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 400000;

   localparam logic [REQ_BITS-1:0] REQ_UNUSED = 2'd3;

   typedef struct {
      logic [REQ_BITS-1:0] op;
      logic [KEY_BITS-1:0] key;
      logic [VAL_BITS-1:0] first;
      logic [VAL_BITS-1:0] second;
      bit                  drain_first;
   } table_req_type;

   typedef struct {
      logic [STATUS_BITS-1:0] status;
      logic [VAL_BITS-1:0]    first;
      logic [VAL_BITS-1:0]    second;
   } table_rsp_type;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [REQ_BITS-1:0]    req_type = REQ_LOOKUP;
   logic [KEY_BITS-1:0]    req_key = '0;
   logic [VAL_BITS-1:0]    req_first_value = '0;
   logic [VAL_BITS-1:0]    req_second_value = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [STATUS_BITS-1:0] rsp_status;
   logic [VAL_BITS-1:0]    rsp_out_first;
   logic [VAL_BITS-1:0]    rsp_out_second;

   bit                  shadow_valid [SLOTS];
   logic [KEY_BITS-1:0] shadow_key [SLOTS];
   logic [VAL_BITS-1:0] shadow_first [SLOTS];
   logic [VAL_BITS-1:0] shadow_second [SLOTS];

   table_req_type  req_pending[$];
   table_rsp_type  rsp_expected[$];
   table_req_type  offered;
   table_rsp_type  due_rsp;
   int             req_count = 0;
   int             rsp_count = 0;
   int             error_count = 0;
   int             cycle_count = 0;
   int             burst_left;
   int             gap_left;
   int             mode_left;
   int             hold_left;
   bit             hold_done;
   stall_mode_type stall_mode;

   hashed_key_value_table #(
      .BUCKETS(BUCKETS),
      .WAYS(WAYS),
      .VALUE_BITS(VAL_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_key(req_key),
      .req_first_value(req_first_value),
      .req_second_value(req_second_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_out_first(rsp_out_first),
      .rsp_out_second(rsp_out_second)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic table_rsp_type table_apply(table_req_type r);
      table_rsp_type rsp;
      int            base;
      int            hit;
      int            free;
      int            w;
      base = int'(r.key % BUCKETS) * WAYS;
      hit = -1;
      free = -1;
      for (w = WAYS - 1; w >= 0; w--) begin
         if (shadow_valid[base + w] && shadow_key[base + w] == r.key) hit = w;
         if (!shadow_valid[base + w]) free = w;
      end
      rsp.status = ST_MISS;
      rsp.first = '0;
      rsp.second = '0;
      case (r.op)
         REQ_INSERT: begin
            if (hit >= 0) begin
               shadow_first[base + hit] = r.first;
               shadow_second[base + hit] = r.second;
               rsp.status = ST_UPDATED;
            end else if (free >= 0) begin
               shadow_valid[base + free] = 1'b1;
               shadow_key[base + free] = r.key;
               shadow_first[base + free] = r.first;
               shadow_second[base + free] = r.second;
               rsp.status = ST_INSERTED;
            end else begin
               rsp.status = ST_FULL;
            end
         end
         REQ_DELETE: begin
            if (hit >= 0) begin
               shadow_valid[base + hit] = 1'b0;
               rsp.status = ST_HIT;
            end
         end
         REQ_LOOKUP: begin
            if (hit >= 0) begin
               rsp.first = shadow_first[base + hit];
               rsp.second = shadow_second[base + hit];
               rsp.status = ST_HIT;
            end
         end
         default: ;
      endcase
      return rsp;
   endfunction

   task automatic queue_req(logic [REQ_BITS-1:0] op, int key, int first, int second,
                            bit drain_first = 1'b0);
      table_req_type r;
      r.op = op;
      r.key = KEY_BITS'(key);
      r.first = VAL_BITS'(first);
      r.second = VAL_BITS'(second);
      r.drain_first = drain_first;
      req_pending.push_back(r);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 1;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            rsp_expected.push_back(table_apply(offered));
            req_count <= req_count + 1;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (req_pending.size() == 0) begin
               req_valid <= 1'b0;
            end else if (req_pending[0].drain_first &&
                         (req_valid || req_count != rsp_count)) begin
               req_valid <= 1'b0;
            end else begin
               offered = req_pending.pop_front();
               req_valid <= 1'b1;
               req_type <= offered.op;
               req_key <= offered.key;
               req_first_value <= offered.first;
               req_second_value <= offered.second;
               burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count <= rsp_count + 1;
         if (rsp_expected.size() == 0) begin
            $error("Response transaction with no request outstanding, status %0d",
                   rsp_status);
            error_count++;
         end else begin
            due_rsp = rsp_expected.pop_front();
            if (rsp_status !== due_rsp.status) begin
               $error("status: expected %0d, got %0d", due_rsp.status, rsp_status);
               error_count++;
            end
            if (rsp_out_first !== due_rsp.first) begin
               $error("out_first: expected %h, got %h", due_rsp.first, rsp_out_first);
               error_count++;
            end
            if (rsp_out_second !== due_rsp.second) begin
               $error("out_second: expected %h, got %h", due_rsp.second, rsp_out_second);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         mode_left = 0;
         hold_left = 0;
         hold_done = 1'b0;
         stall_mode = STALL_NONE;
      end else begin
         if (!hold_done && rsp_count >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = stall_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            case (stall_mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default:     rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL hashed_key_value_table");
         $finish;
      end
   end

   initial begin
      int                  hot [HOT_COUNT];
      int                  i;
      int                  pick;
      int                  bucket;
      int                  tag;
      int                  key;
      int                  first;
      int                  second;
      logic [REQ_BITS-1:0] op;

      queue_req(REQ_LOOKUP, 0, 16'h1234, 16'h5678);
      queue_req(REQ_DELETE, 0, 0, 0);
      queue_req(REQ_INSERT, 0, 16'h0000, 16'h0000);
      queue_req(REQ_INSERT, 0, 16'hffff, 16'hffff);
      queue_req(REQ_LOOKUP, 0, 0, 0);
      queue_req(REQ_INSERT, 32'h7fffffff, 16'ha5a5, 16'h5a5a);
      queue_req(REQ_LOOKUP, 32'h7fffffff, 16'hffff, 16'hffff);
      queue_req(REQ_INSERT, 5, 16'h0001, 16'h8000);
      queue_req(REQ_INSERT, 5 + BUCKETS, 16'h0002, 16'h4000);
      queue_req(REQ_INSERT, 5 + 2 * BUCKETS, 16'h0003, 16'h2000);
      queue_req(REQ_INSERT, 5 + 3 * BUCKETS, 16'h0004, 16'h1000);
      queue_req(REQ_INSERT, 5 + 4 * BUCKETS, 16'h0005, 16'h0800);
      queue_req(REQ_LOOKUP, 5 + 2 * BUCKETS, 0, 0);
      queue_req(REQ_DELETE, 5 + BUCKETS, 0, 0);
      queue_req(REQ_LOOKUP, 5 + BUCKETS, 0, 0);
      queue_req(REQ_INSERT, 5 + 4 * BUCKETS, 16'h0006, 16'h0400);
      queue_req(REQ_LOOKUP, 5 + 4 * BUCKETS, 0, 0);
      queue_req(REQ_UNUSED, 5, 16'hffff, 16'hffff);
      queue_req(REQ_LOOKUP, 5, 0, 0);
      queue_req(REQ_DELETE, 0, 0, 0);
      queue_req(REQ_LOOKUP, 0, 0, 0);
      queue_req(REQ_DELETE, 32'h7fffffff, 0, 0);
      queue_req(REQ_LOOKUP, 32'h7fffffff, 0, 0);

      hot[0] = 0;
      hot[1] = BUCKETS - 1;
      for (i = 2; i < HOT_COUNT; i++) hot[i] = $urandom_range(0, BUCKETS - 1);

      for (i = 0; i < RANDOM_REQS; i++) begin
         bucket = ($urandom_range(0, 99) < 70) ? hot[$urandom_range(0, HOT_COUNT - 1)]
                                               : $urandom_range(0, BUCKETS - 1);
         tag = ($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_TAG)
                                           : $urandom_range(0, 5);
         key = tag * BUCKETS + bucket;
         if ($urandom_range(0, 19) == 0) key = int'($urandom & 32'h7fffffff);
         pick = $urandom_range(0, 99);
         if (pick < 45) op = REQ_INSERT;
         else if (pick < 65) op = REQ_DELETE;
         else if (pick < 95) op = REQ_LOOKUP;
         else op = REQ_UNUSED;
         first = $urandom_range(0, 65535);
         second = $urandom_range(0, 65535);
         if ($urandom_range(0, 9) == 0) first = ($urandom_range(0, 1) == 0) ? 0 : 65535;
         if ($urandom_range(0, 9) == 0) second = ($urandom_range(0, 1) == 0) ? 0 : 65535;
         queue_req(op, key, first, second, i == 0 || i == 300 || i == 1000);
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (req_pending.size() != 0 || req_valid || rsp_expected.size() != 0)
         @(negedge clock);
      repeat (16) @(negedge clock);
      if (error_count == 0) begin
         $display("PASS hashed_key_value_table");
      end else begin
         $display("FAIL hashed_key_value_table");
      end
      $finish;
   end

endmodule
